// File: src/pds_pkg.sv
// pds_pkg: limits and types shared by the pll divider search pipeline
// no dependencies
`default_nettype none
package pds_pkg;
  localparam int unsigned FreqW   = 20;
  localparam int unsigned ErrW    = 17;
  localparam int unsigned InfinMin = 8000;
  localparam int unsigned InfinMax = 50000;
  localparam int unsigned VcoMin  = 500000;
  localparam int unsigned VcoMax  = 1000000;
  localparam int unsigned MultMin = 10;
  localparam int unsigned MultMax = 125;
  localparam int unsigned ErrLimit = 100000;

  // running best candidate carried along the pipeline
  typedef struct packed {
    logic            hit;
    logic [2:0]      in_div;
    logic [3:0]      out_div;
    logic [6:0]      mult;
    logic [ErrW-1:0] err;
  } best_t;
endpackage
`default_nettype wire

// File: src/pll_divider_search.sv
// pll_divider_search: picks input/output dividers and multiplier for a pll
// top level; uses pds_pkg and a chain of pds_cand stages
//
// usage: one request per s_axis transfer, tdata = {target_khz, ref_khz}.
// each request passes through one pds_cand stage per divider pair
// (MAX_IN_DIV times the number of power-of-two output dividers), each a
// constant reciprocal multiply for ref / i, a pipelined divider for vco / infin
// (FreqW + 4 quotient bits, one per stage), a multiply and a compare stage, each
// registered. a new request is taken every cycle while m_axis does not stall;
// each result leaves through the output register.
// result on m_axis tdata = {error_khz, mult, out_div, in_div, found}.
// the whole pipe advances only when the output register is empty or being
// taken, so a stall on m_axis holds every stage and loses nothing.
// reset clears all valid bits; no item is in flight afterwards.
`default_nettype none
module pll_divider_search #(
  parameter int unsigned MAX_IN_DIV  = 7,
  parameter int unsigned MAX_OUT_DIV = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // ref_khz[19:0], target_khz[39:20]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // found, in_div, out_div, mult, error_khz
);
  localparam int unsigned FW = pds_pkg::FreqW;
  localparam int unsigned NO = $clog2(MAX_OUT_DIV + 1);
  localparam int unsigned NP = MAX_IN_DIV * NO;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic           v   [NP+1];
  logic [FW-1:0]  rf  [NP+1];
  logic [FW-1:0]  tg  [NP+1];
  pds_pkg::best_t bs  [NP+1];

  assign v[0]  = s_axis_tvalid;
  assign rf[0] = s_axis_tdata[FW-1:0];
  assign tg[0] = s_axis_tdata[2*FW-1:FW];
  assign bs[0] = '0;

  for (genvar k = 0; k < NP; k++) begin : g_c
    pds_cand #(.InDiv(k / NO + 1), .OutSh(k % NO)) u_c (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(v[k]), .ref_i(rf[k]), .tgt_i(tg[k]), .best_i(bs[k]),
      .valid_o(v[k+1]), .ref_o(rf[k+1]), .tgt_o(tg[k+1]), .best_o(bs[k+1])
    );
  end

  logic           ov_q;
  pds_pkg::best_t ob_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= v[NP];
  end
  always_ff @(posedge clk_i) begin
    if (en) ob_q <= bs[NP];
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {ob_q.err, ob_q.mult, ob_q.out_div, ob_q.in_div, ob_q.hit};

  // a not-found result carries all-zero dividers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !ob_q.hit |-> ob_q.in_div == 3'd0 && ob_q.mult == 7'd0)
    else $error("not-found result with nonzero fields");
  // a found result never carries the limit error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ob_q.hit |-> 32'(ob_q.err) < pds_pkg::ErrLimit)
    else $error("error above limit");
  // stalled output holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
endmodule
`default_nettype wire

// File: src/pds_div.sv
// pds_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing but its parameters
`default_nettype none
module pds_div #(
  parameter int unsigned NumW = 24,
  parameter int unsigned DenW = 20,
  parameter int unsigned TagW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  input  wire logic [TagW-1:0] tag_i,
  output logic                 valid_o,
  output logic [NumW-1:0]      quo_o,
  output logic [TagW-1:0]      tag_o
);
  localparam int unsigned RemW = DenW + 1;
  logic [NumW:1]     v_q;
  logic [NumW-1:0]   n_q [1:NumW];
  logic [RemW-1:0]   r_q [1:NumW];
  logic [DenW-1:0]   d_q [1:NumW];
  logic [TagW-1:0]   t_q [1:NumW];

  for (genvar s = 0; s < NumW; s++) begin : g_st
    logic            v_in;
    logic [NumW-1:0] n_in;
    logic [RemW-1:0] r_in;
    logic [DenW-1:0] d_in;
    logic [TagW-1:0] t_in;
    logic [RemW:0]   sh;
    logic [RemW:0]   df;
    logic            ge;
    if (s == 0) begin : g_head
      assign v_in = valid_i;
      assign n_in = num_i;
      assign r_in = '0;
      assign d_in = den_i;
      assign t_in = tag_i;
    end else begin : g_body
      assign v_in = v_q[s];
      assign n_in = n_q[s];
      assign r_in = r_q[s];
      assign d_in = d_q[s];
      assign t_in = t_q[s];
    end
    assign sh = {r_in, n_in[NumW-1]};
    assign df = sh - {2'b00, d_in};
    assign ge = !df[RemW];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1] <= ge ? df[RemW-1:0] : sh[RemW-1:0];
        n_q[s+1] <= {n_in[NumW-2:0], ge};
        d_q[s+1] <= d_in;
        t_q[s+1] <= t_in;
      end
    end
  end

  assign valid_o = v_q[NumW];
  assign quo_o   = n_q[NumW];
  assign tag_o   = t_q[NumW];
endmodule
`default_nettype wire

// File: src/pds_cand.sv
// pds_cand: one candidate set (input divider i, output divider o) per request
// ref / i by reciprocal multiply, vco / infin by pipelined divider, limits, best; uses pds_pkg
`default_nettype none
module pds_cand #(
  parameter int unsigned InDiv  = 1,
  parameter int unsigned OutSh  = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [pds_pkg::FreqW-1:0] ref_i,
  input  wire logic [pds_pkg::FreqW-1:0] tgt_i,
  input  wire pds_pkg::best_t            best_i,
  output logic                           valid_o,
  output logic [pds_pkg::FreqW-1:0]      ref_o,
  output logic [pds_pkg::FreqW-1:0]      tgt_o,
  output pds_pkg::best_t                 best_o
);
  localparam int unsigned FW = pds_pkg::FreqW;
  localparam int unsigned BW = $bits(pds_pkg::best_t);
  localparam int unsigned VW = FW + 4;
  localparam int unsigned TagW = 2*FW + BW;
  // ceil(2^RecSh / i) gives the exact floor quotient for any i up to 16
  localparam int unsigned RecSh = FW + 4;
  localparam logic [RecSh:0] Recip =
    (RecSh+1)'(((64'd1 << RecSh) + 64'(InDiv) - 64'd1) / 64'(InDiv));

  // stage a: ref / i
  logic [FW+RecSh:0] ra;
  logic              va_q;
  logic [FW-1:0]     infin_q;
  logic [TagW-1:0]   ta_q;
  assign ra = (FW+RecSh+1)'(ref_i) * (FW+RecSh+1)'(Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en_i) va_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      infin_q <= ra[RecSh +: FW];
      ta_q    <= {ref_i, tgt_i, best_i};
    end
  end

  logic [VW-1:0] vco;
  logic          inf_ok;
  assign vco    = {4'd0, ta_q[BW +: FW]} << OutSh;
  assign inf_ok = infin_q >= FW'(pds_pkg::InfinMin) && infin_q <= FW'(pds_pkg::InfinMax);

  // stage b: vco / infin, tag also carries infin and ok
  logic            vb;
  logic [VW-1:0]   n;
  logic [TagW+FW:0] tb;
  pds_div #(.NumW(VW), .DenW(FW), .TagW(TagW+FW+1)) u_db (
    .clk_i, .rst_ni, .en_i, .valid_i(va_q),
    .num_i(vco), .den_i(infin_q), .tag_i({inf_ok, infin_q, ta_q}),
    .valid_o(vb), .quo_o(n), .tag_o(tb)
  );

  // stage c: product infin*n
  logic             vc_q;
  logic [FW+6:0]    prod_q;
  logic             ok_q;
  logic [6:0]       n_q;
  logic [TagW-1:0]  tc_q;
  logic [VW-1:0]    vco_b;
  logic             ok_b;
  assign vco_b = {4'd0, tb[BW +: FW]} << OutSh;
  assign ok_b  = tb[TagW+FW]
                 && vco_b >= VW'(pds_pkg::VcoMin) && vco_b <= VW'(pds_pkg::VcoMax)
                 && n >= VW'(pds_pkg::MultMin) && n <= VW'(pds_pkg::MultMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (en_i) vc_q <= vb;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (FW+7)'(tb[TagW +: FW]) * (FW+7)'(n[6:0]);
      ok_q   <= ok_b;
      n_q    <= n[6:0];
      tc_q   <= tb[TagW-1:0];
    end
  end

  // stage d: error and compare
  logic [FW+6:0]  f;
  logic [FW+7:0]  e;
  logic [FW-1:0]  tg;
  pds_pkg::best_t bin, bnew;
  assign tg  = tc_q[BW +: FW];
  assign bin = tc_q[BW-1:0];
  assign f   = prod_q >> OutSh;
  assign e   = (f > {7'd0, tg}) ? {1'b0, f - {7'd0, tg}} : {1'b0, {7'd0, tg} - f};
  always_comb begin
    bnew = bin;
    if (ok_q && e < (FW+8)'(bin.hit ? 32'(bin.err) : pds_pkg::ErrLimit)) begin
      bnew.hit     = 1'b1;
      bnew.in_div  = 3'(InDiv);
      bnew.out_div = 4'(1 << OutSh);
      bnew.mult    = n_q;
      bnew.err     = e[pds_pkg::ErrW-1:0];
    end
  end

  logic vd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else if (en_i) vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ref_o  <= tc_q[BW+FW +: FW];
      tgt_o  <= tg;
      best_o <= bnew;
    end
  end
  assign valid_o = vd_q;
endmodule
`default_nettype wire

// File: tb/tb_pll_divider_search.sv
// tb_pll_divider_search: self-checking bench for the pll divider search block
// depends on pds_pkg and pll_divider_search; predicts each answer in-bench
`timescale 1ns / 100ps
`default_nettype none
module tb_pll_divider_search;

  typedef struct packed {
    logic                     hit;
    logic [2:0]               in_div;
    logic [3:0]               out_div;
    logic [6:0]               mult;
    logic [pds_pkg::ErrW-1:0] err;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  answer_t     pending_answers[$];
  int unsigned fail_cnt = 0;
  longint      cycle_cnt = 0;
  bit          idle_on = 1'b1;

  pll_divider_search u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // best divider set: i ascending, then o ascending, strict improvement only
  function automatic answer_t best_dividers(logic [19:0] ref_f, logic [19:0] tgt_f);
    answer_t a;
    longint unsigned infin, vco, n, f, err, best_err, i, o, tgt;
    a = '0;
    tgt = 64'(tgt_f);
    best_err = 64'(pds_pkg::ErrLimit);
    for (i = 1; i <= 7; i++) begin
      infin = 64'(ref_f) / i;
      if (infin < 64'(pds_pkg::InfinMin) || infin > 64'(pds_pkg::InfinMax)) continue;
      for (o = 1; o <= 8; o = o << 1) begin
        vco = tgt * o;
        if (vco < 64'(pds_pkg::VcoMin) || vco > 64'(pds_pkg::VcoMax)) continue;
        n = vco / infin;
        if (n < 64'(pds_pkg::MultMin) || n > 64'(pds_pkg::MultMax)) continue;
        f = (infin * n) / o;
        err = (f > tgt) ? f - tgt : tgt - f;
        if (err < best_err) begin
          best_err = err;
          a.hit = 1'b1;
          a.in_div = i[2:0];
          a.out_div = o[3:0];
          a.mult = n[6:0];
          a.err = best_err[pds_pkg::ErrW-1:0];
        end
      end
    end
    return a;
  endfunction

  task automatic send_request(logic [19:0] ref_f, logic [19:0] tgt_f);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tdata <= {tgt_f, ref_f};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_answers.push_back(best_dividers(ref_f, tgt_f));
    @(negedge clk_i);
  endtask

  // output side backpressure, changed at the falling edge
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    answer_t exp_a, got;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hit     = m_axis_tdata[0];
      got.in_div  = m_axis_tdata[3:1];
      got.out_div = m_axis_tdata[7:4];
      got.mult    = m_axis_tdata[14:8];
      got.err     = m_axis_tdata[31:15];
      if (pending_answers.size() == 0) begin
        $error("result transfer with no request outstanding");
        fail_cnt++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (got.hit !== exp_a.hit) begin
          $error("found: expected %0d, got %0d", exp_a.hit, got.hit); fail_cnt++;
        end
        if (got.in_div !== exp_a.in_div) begin
          $error("in_div: expected %0d, got %0d", exp_a.in_div, got.in_div); fail_cnt++;
        end
        if (got.out_div !== exp_a.out_div) begin
          $error("out_div: expected %0d, got %0d", exp_a.out_div, got.out_div); fail_cnt++;
        end
        if (got.mult !== exp_a.mult) begin
          $error("mult: expected %0d, got %0d", exp_a.mult, got.mult); fail_cnt++;
        end
        if (got.err !== exp_a.err) begin
          $error("error_khz: expected %0d, got %0d", exp_a.err, got.err); fail_cnt++;
        end
      end
    end
    if (cycle_cnt > 3000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(20'd0, 20'd0);
    send_request(20'hFFFFF, 20'hFFFFF);
    send_request(20'd24000, 20'd148500);   // ordinary match
    send_request(20'd8000, 20'd500000);    // divided input at its floor
    send_request(20'd50000, 20'd1000000);  // top of input and vco ranges
    send_request(20'd7999, 20'd600000);    // divided input too low
    send_request(20'd350007, 20'd100000);  // divided input too high for every in_div
    send_request(20'd50000, 20'd62500);    // vco needs out_div 8
    send_request(20'd8000, 20'd62499);     // vco just under floor for all
    send_request(20'd10000, 20'd1000001);  // vco above ceiling
    send_request(20'd50000, 20'd999999);   // multiplier near floor
    send_request(20'd8000, 20'd999999);    // multiplier just under ceiling
    send_request(20'd8000, 20'd1000000);   // multiplier exactly 125
    send_request(20'd27000, 20'd500001);   // best candidate at in_div 2, mult 37
    send_request(20'd49999, 20'd781250);
    send_request(20'd12345, 20'd543210);
    send_request(20'hAAAAA, 20'h55555);
    send_request(20'h55555, 20'hAAAAA);
  endtask

  task automatic test_random(int unsigned count);
    logic [19:0] r, t;
    for (int unsigned k = 0; k < count; k++) begin
      case ($urandom_range(0, 3))
        0: begin r = 20'($urandom); t = 20'($urandom); end
        1: begin
          r = 20'($urandom_range(8000, 350000));
          t = 20'($urandom_range(62500, 1000000));
        end
        default: begin
          r = 20'($urandom_range(8000, 50000) * $urandom_range(1, 7));
          t = 20'($urandom_range(62500, 1000000));
        end
      endcase
      send_request(r, t);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(1800);
    idle_on = 1'b0;
    test_random(200);
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
    if (fail_cnt == 0 && pending_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
